@@ src/hue_cycle_rgb_driver_macros.svh @@
// ----------------------------------------------------------------------------
// Hue cycle RGB driver assertion macros
// Property macros for the checks in the driver's controller module.
// ----------------------------------------------------------------------------
`ifndef HUE_CYCLE_RGB_DRIVER_MACROS_SVH
`define HUE_CYCLE_RGB_DRIVER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define HCRD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hcrd: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define HCRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hcrd: next-cycle check failed");

`endif

@@ src/hcrd_pkg.sv @@
// ----------------------------------------------------------------------------
// Hue cycle RGB driver package
// Widths, constants, shared types and helper functions of the driver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hcrd_pkg;

    localparam int RATE_W  = 16;
    localparam int TIME_W  = 10;
    localparam int CHAN_W  = 8;
    localparam int PHASE_W = 15;
    localparam int FR_W    = 12;
    localparam int PROD_W  = 26;
    localparam int MAG_W   = PROD_W - TIME_W;
    localparam int SUM_W   = 17;
    localparam int NUM_W   = 20;
    localparam int PP_W    = 16;
    localparam int DIV_W   = 28;
    localparam int SECT_W  = 3;
    localparam int IDX_W   = 2;

    // The fraction scale is 256 times 3825. A channel numerator is shifted
    // down by eight and multiplied by 2^32 / 3825 rounded up, which gives the
    // exact quotient for every numerator the channels can produce.
    localparam int NUM_SHIFT   = 8;
    localparam int RECIP_W     = 21;
    localparam int RECIP_SHIFT = 32;
    localparam int RPROD_W     = DIV_W - NUM_SHIFT + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP = 21'd1122868;

    localparam logic [IDX_W-1:0] REG_HUE_RATE   = 2'd0;
    localparam logic [IDX_W-1:0] REG_SATURATION = 2'd1;
    localparam logic [IDX_W-1:0] REG_BRIGHTNESS = 2'd2;

    localparam logic signed [RATE_W-1:0] RATE_RESET = 16'sd0;
    localparam logic [CHAN_W-1:0] CHAN_FULL = 8'd255;

    localparam logic signed [SUM_W-1:0] TURN_S     = 17'sd23040;
    localparam logic signed [SUM_W-1:0] TWO_TURN_S = 17'sd46080;
    localparam logic signed [SUM_W-1:0] NEG_TURN_S = -17'sd23040;

    localparam logic [FR_W-1:0]  SECTOR_FR  = 12'd3840;
    localparam logic [NUM_W-1:0] FRAC_SCALE = 20'd979200;

    localparam logic [SECT_W-1:0] SECT_RED_YELLOW    = 3'd0;
    localparam logic [SECT_W-1:0] SECT_YELLOW_GREEN  = 3'd1;
    localparam logic [SECT_W-1:0] SECT_GREEN_CYAN    = 3'd2;
    localparam logic [SECT_W-1:0] SECT_CYAN_BLUE     = 3'd3;
    localparam logic [SECT_W-1:0] SECT_BLUE_MAGENTA  = 3'd4;
    localparam logic [SECT_W-1:0] SECT_MAGENTA_RED   = 3'd5;

    typedef struct packed {
        logic signed [RATE_W-1:0] hue_rate;
        logic [CHAN_W-1:0]        saturation;
        logic [CHAN_W-1:0]        brightness;
    } t_cfg;

    typedef struct packed {
        logic take_in;
        logic wrap;
        logic sect;
        logic prod1;
        logic prod2;
        logic div;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

    function automatic logic [PHASE_W-1:0] sector_base(input logic [SECT_W-1:0] sect);
        logic [PHASE_W-1:0] base;
        unique case (sect)
            SECT_RED_YELLOW:   base = 15'd0;
            SECT_YELLOW_GREEN: base = 15'd3840;
            SECT_GREEN_CYAN:   base = 15'd7680;
            SECT_CYAN_BLUE:    base = 15'd11520;
            SECT_BLUE_MAGENTA: base = 15'd15360;
            SECT_MAGENTA_RED:  base = 15'd19200;
            default:           base = 15'd0;
        endcase
        return base;
    endfunction

endpackage

@@ src/hcrd_cfg.sv @@
// ----------------------------------------------------------------------------
// Hue cycle RGB driver configuration registers
// Holds hue rate, saturation and brightness, written over the config port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcrd_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [hcrd_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [hcrd_pkg::RATE_W-1:0] i_cfg_data,
    output hcrd_pkg::t_cfg              o_cfg
);

    hcrd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hue_rate   <= hcrd_pkg::RATE_RESET;
            r_cfg.saturation <= hcrd_pkg::CHAN_FULL;
            r_cfg.brightness <= hcrd_pkg::CHAN_FULL;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                hcrd_pkg::REG_HUE_RATE: begin
                    r_cfg.hue_rate <= $signed(i_cfg_data);
                end
                hcrd_pkg::REG_SATURATION: begin
                    r_cfg.saturation <= i_cfg_data[hcrd_pkg::CHAN_W-1:0];
                end
                hcrd_pkg::REG_BRIGHTNESS: begin
                    r_cfg.brightness <= i_cfg_data[hcrd_pkg::CHAN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

endmodule

@@ src/hcrd_dp.sv @@
// ----------------------------------------------------------------------------
// Hue cycle RGB driver datapath
// Phase accumulation and wrap, sector split, channel products, a reciprocal
// multiply that divides the three channel numerators, and the output word
// register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcrd_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hcrd_pkg::t_cfg              i_cfg,
    input  hcrd_pkg::t_dp_cmd           i_cmd,
    output hcrd_pkg::t_dp_stat          o_stat,
    input  logic [hcrd_pkg::TIME_W-1:0] i_elapsed_time,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic [hcrd_pkg::CHAN_W-1:0] o_red,
    output logic [hcrd_pkg::CHAN_W-1:0] o_green,
    output logic [hcrd_pkg::CHAN_W-1:0] o_blue
);

    logic signed [hcrd_pkg::RATE_W+hcrd_pkg::TIME_W:0] w_full;
    logic signed [hcrd_pkg::PROD_W-1:0] r_prod;
    logic [hcrd_pkg::PROD_W-1:0]        w_abs;
    logic [hcrd_pkg::MAG_W-1:0]         w_mag;
    logic signed [hcrd_pkg::SUM_W-1:0]  w_adv;
    logic signed [hcrd_pkg::SUM_W-1:0]  w_sum;
    logic [hcrd_pkg::PHASE_W-1:0]       r_phase;
    logic [hcrd_pkg::PHASE_W-1:0]       n_phase;
    logic [hcrd_pkg::SECT_W-1:0]        r_sect;
    logic [hcrd_pkg::SECT_W-1:0]        n_sect;
    logic [hcrd_pkg::FR_W-1:0]          r_fr;
    logic [hcrd_pkg::FR_W-1:0]          n_fr;
    logic [hcrd_pkg::FR_W-1:0]          w_tfr;
    logic [hcrd_pkg::NUM_W-1:0]         r_sfr_q;
    logic [hcrd_pkg::NUM_W-1:0]         r_sfr_t;
    logic [hcrd_pkg::NUM_W-1:0]         n_sfr_q;
    logic [hcrd_pkg::NUM_W-1:0]         n_sfr_t;
    logic [hcrd_pkg::PP_W-1:0]          r_pp;
    logic [hcrd_pkg::PP_W-1:0]          n_pp;
    logic [hcrd_pkg::DIV_W-1:0]         w_pp_ext;
    logic [hcrd_pkg::DIV_W-1:0]         n_xq;
    logic [hcrd_pkg::DIV_W-1:0]         n_xt;
    logic [hcrd_pkg::DIV_W-1:0]         n_xp;
    logic [hcrd_pkg::DIV_W-1:0]         r_num_q;
    logic [hcrd_pkg::DIV_W-1:0]         r_num_t;
    logic [hcrd_pkg::DIV_W-1:0]         r_num_p;
    logic [hcrd_pkg::RPROD_W-1:0]       w_mq;
    logic [hcrd_pkg::RPROD_W-1:0]       w_mt;
    logic [hcrd_pkg::RPROD_W-1:0]       w_mp;
    logic [hcrd_pkg::CHAN_W-1:0]        r_quo_q;
    logic [hcrd_pkg::CHAN_W-1:0]        r_quo_t;
    logic [hcrd_pkg::CHAN_W-1:0]        r_quo_p;
    logic [hcrd_pkg::CHAN_W-1:0]        n_red;
    logic [hcrd_pkg::CHAN_W-1:0]        n_green;
    logic [hcrd_pkg::CHAN_W-1:0]        n_blue;
    logic                               r_out_valid;
    logic [hcrd_pkg::CHAN_W-1:0]        r_red;
    logic [hcrd_pkg::CHAN_W-1:0]        r_green;
    logic [hcrd_pkg::CHAN_W-1:0]        r_blue;

    assign w_full = i_cfg.hue_rate * $signed({1'b0, i_elapsed_time});

    // The advance truncates toward zero, so the magnitude is shifted.
    assign w_abs = r_prod[hcrd_pkg::PROD_W-1] ? hcrd_pkg::PROD_W'(-r_prod) : r_prod;
    assign w_mag = w_abs[hcrd_pkg::PROD_W-1:hcrd_pkg::TIME_W];
    assign w_adv = r_prod[hcrd_pkg::PROD_W-1] ? -$signed({1'b0, w_mag})
                                               : $signed({1'b0, w_mag});
    assign w_sum = $signed({2'b00, r_phase}) + w_adv;

    always_comb begin
        if (w_sum >= hcrd_pkg::TWO_TURN_S) begin
            n_phase = hcrd_pkg::PHASE_W'(w_sum - hcrd_pkg::TWO_TURN_S);
        end else if (w_sum >= hcrd_pkg::TURN_S) begin
            n_phase = hcrd_pkg::PHASE_W'(w_sum - hcrd_pkg::TURN_S);
        end else if (w_sum < hcrd_pkg::NEG_TURN_S) begin
            n_phase = hcrd_pkg::PHASE_W'(w_sum + hcrd_pkg::TWO_TURN_S);
        end else if (w_sum < 17'sd0) begin
            n_phase = hcrd_pkg::PHASE_W'(w_sum + hcrd_pkg::TURN_S);
        end else begin
            n_phase = hcrd_pkg::PHASE_W'(w_sum);
        end
    end

    always_comb begin
        if (r_phase >= hcrd_pkg::sector_base(hcrd_pkg::SECT_MAGENTA_RED)) begin
            n_sect = hcrd_pkg::SECT_MAGENTA_RED;
        end else if (r_phase >= hcrd_pkg::sector_base(hcrd_pkg::SECT_BLUE_MAGENTA)) begin
            n_sect = hcrd_pkg::SECT_BLUE_MAGENTA;
        end else if (r_phase >= hcrd_pkg::sector_base(hcrd_pkg::SECT_CYAN_BLUE)) begin
            n_sect = hcrd_pkg::SECT_CYAN_BLUE;
        end else if (r_phase >= hcrd_pkg::sector_base(hcrd_pkg::SECT_GREEN_CYAN)) begin
            n_sect = hcrd_pkg::SECT_GREEN_CYAN;
        end else if (r_phase >= hcrd_pkg::sector_base(hcrd_pkg::SECT_YELLOW_GREEN)) begin
            n_sect = hcrd_pkg::SECT_YELLOW_GREEN;
        end else begin
            n_sect = hcrd_pkg::SECT_RED_YELLOW;
        end
    end

    assign n_fr     = hcrd_pkg::FR_W'(r_phase - hcrd_pkg::sector_base(n_sect));
    assign w_tfr    = hcrd_pkg::SECTOR_FR - r_fr;
    assign n_sfr_q  = i_cfg.saturation * r_fr;
    assign n_sfr_t  = i_cfg.saturation * w_tfr;
    assign n_pp     = i_cfg.brightness * (hcrd_pkg::CHAN_FULL - i_cfg.saturation);
    assign w_pp_ext = {{(hcrd_pkg::DIV_W-hcrd_pkg::PP_W){1'b0}}, r_pp};
    assign n_xq     = i_cfg.brightness * (hcrd_pkg::FRAC_SCALE - r_sfr_q);
    assign n_xt     = i_cfg.brightness * (hcrd_pkg::FRAC_SCALE - r_sfr_t);
    assign n_xp     = (w_pp_ext << 12) - (w_pp_ext << 8);

    assign w_mq = r_num_q[hcrd_pkg::DIV_W-1:hcrd_pkg::NUM_SHIFT] * hcrd_pkg::RECIP;
    assign w_mt = r_num_t[hcrd_pkg::DIV_W-1:hcrd_pkg::NUM_SHIFT] * hcrd_pkg::RECIP;
    assign w_mp = r_num_p[hcrd_pkg::DIV_W-1:hcrd_pkg::NUM_SHIFT] * hcrd_pkg::RECIP;

    always_comb begin
        unique case (r_sect)
            hcrd_pkg::SECT_RED_YELLOW: begin
                n_red = i_cfg.brightness; n_green = r_quo_t; n_blue = r_quo_p;
            end
            hcrd_pkg::SECT_YELLOW_GREEN: begin
                n_red = r_quo_q; n_green = i_cfg.brightness; n_blue = r_quo_p;
            end
            hcrd_pkg::SECT_GREEN_CYAN: begin
                n_red = r_quo_p; n_green = i_cfg.brightness; n_blue = r_quo_t;
            end
            hcrd_pkg::SECT_CYAN_BLUE: begin
                n_red = r_quo_p; n_green = r_quo_q; n_blue = i_cfg.brightness;
            end
            hcrd_pkg::SECT_BLUE_MAGENTA: begin
                n_red = r_quo_t; n_green = r_quo_p; n_blue = i_cfg.brightness;
            end
            default: begin
                n_red = i_cfg.brightness; n_green = r_quo_p; n_blue = r_quo_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.wrap) begin
                r_phase <= n_phase;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_prod <= $signed(w_full[hcrd_pkg::PROD_W-1:0]);
        end
        if (i_cmd.sect) begin
            r_sect <= n_sect;
            r_fr   <= n_fr;
        end
        if (i_cmd.prod1) begin
            r_sfr_q <= n_sfr_q;
            r_sfr_t <= n_sfr_t;
            r_pp    <= n_pp;
        end
        if (i_cmd.prod2) begin
            r_num_q <= n_xq;
            r_num_t <= n_xt;
            r_num_p <= n_xp;
        end
        if (i_cmd.div) begin
            r_quo_q <= w_mq[hcrd_pkg::RECIP_SHIFT +: hcrd_pkg::CHAN_W];
            r_quo_t <= w_mt[hcrd_pkg::RECIP_SHIFT +: hcrd_pkg::CHAN_W];
            r_quo_p <= w_mp[hcrd_pkg::RECIP_SHIFT +: hcrd_pkg::CHAN_W];
        end
        if (i_cmd.load_out) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_red           = r_red;
    assign o_green         = r_green;
    assign o_blue          = r_blue;

endmodule

@@ src/hcrd_ctrl.sv @@
// ----------------------------------------------------------------------------
// Hue cycle RGB driver controller
// Sequences one word through wrap, sector, product and divide steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hue_cycle_rgb_driver_macros.svh"

module hcrd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  hcrd_pkg::t_dp_stat i_stat,
    output hcrd_pkg::t_dp_cmd  o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WRAP  = 3'd1;
    localparam logic [2:0] ST_SECT  = 3'd2;
    localparam logic [2:0] ST_PROD1 = 3'd3;
    localparam logic [2:0] ST_PROD2 = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take_in = 1'b1;
                    n_state       = ST_WRAP;
                end
            end
            ST_WRAP: begin
                o_cmd.wrap = 1'b1;
                n_state    = ST_SECT;
            end
            ST_SECT: begin
                o_cmd.sect = 1'b1;
                n_state    = ST_PROD1;
            end
            ST_PROD1: begin
                o_cmd.prod1 = 1'b1;
                n_state     = ST_PROD2;
            end
            ST_PROD2: begin
                o_cmd.prod2 = 1'b1;
                n_state     = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = ST_OUT;
            end
            ST_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

    `HCRD_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, (r_state == ST_IDLE) && i_in_valid, r_state == ST_WRAP)
    `HCRD_ASSERT_NEXT(a_div_to_out, i_clk, i_rst_n, r_state == ST_DIV, r_state == ST_OUT)
    `HCRD_ASSERT_NEXT(a_out_returns_idle, i_clk, i_rst_n, (r_state == ST_OUT) && i_stat.out_free, r_state == ST_IDLE)

endmodule

@@ src/hue_cycle_rgb_driver.sv @@
// ----------------------------------------------------------------------------
// Hue cycle RGB driver
// Advances a hue phase by rate times elapsed time and converts it, with the
// configured saturation and brightness, to an 8-bit RGB color.
//
//   Channel  Direction  Handshake               Word
//   in       input      i_in_valid/o_in_stall   i_elapsed_time
//   out      output     o_out_valid/i_out_stall o_red, o_green, o_blue
//   cfg      input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// Each accepted word steps through the wrap, sector, product, divide and output
// states before the next word is accepted; the divide step divides the three
// channel numerators by a shift and a reciprocal multiply.
// Reset is synchronous; it returns the hue phase to zero.
// A stalled result holds the sequence at its final step; a new word is
// accepted while an earlier result still waits in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hue_cycle_rgb_driver (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [hcrd_pkg::TIME_W-1:0] i_elapsed_time,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [hcrd_pkg::CHAN_W-1:0] o_red,
    output logic [hcrd_pkg::CHAN_W-1:0] o_green,
    output logic [hcrd_pkg::CHAN_W-1:0] o_blue,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [hcrd_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [hcrd_pkg::RATE_W-1:0] i_cfg_data
);

    hcrd_pkg::t_cfg     w_cfg;
    hcrd_pkg::t_dp_cmd  w_cmd;
    hcrd_pkg::t_dp_stat w_stat;

    hcrd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    hcrd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    hcrd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_elapsed_time (i_elapsed_time),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue)
    );

endmodule

@@ tb/hue_cycle_rgb_driver_test.sv @@
// ----------------------------------------------------------------------------
// Hue cycle RGB driver testbench
// Sends elapsed-time words through the valid/stall input, computes each color
// with a local model of the hue phase and the HSV conversion or takes typed
// rows' colors from the table, and compares every output word field by field.
// A short directed table comes first, then random words in segments opened by
// random register writes, under three patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hue_cycle_rgb_driver_test;

    import hcrd_pkg::*;

    localparam int HUE_TURN     = 23040;
    localparam int SECTOR_SPAN  = 3840;
    localparam int FRAC_SPAN    = 979200;
    localparam int LATENCY      = 12;
    localparam int QUIET_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 250;
    localparam int SEGMENTS     = 28;
    localparam int SEG_WORDS    = 50;
    localparam int PLAN_LEN     = 28;

    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic              is_cfg;
        logic [IDX_W-1:0]  idx;
        logic [RATE_W-1:0] data;
        logic [TIME_W-1:0] dt;
        logic              typed;
        t_rgb              rgb;
    } t_row;

    localparam t_row PLAN [PLAN_LEN] = '{
        '{1'b0, REG_HUE_RATE,   16'd0,      10'd0,    1'b1, '{8'd255, 8'd0, 8'd0}},
        '{1'b0, REG_HUE_RATE,   16'd0,      10'd1023, 1'b1, '{8'd255, 8'd0, 8'd0}},
        '{1'b1, REG_SATURATION, 16'd0,      10'd0,    1'b0, '{8'd0, 8'd0, 8'd0}},
        '{1'b0, REG_HUE_RATE,   16'd0,      10'd1023, 1'b1, '{8'd255, 8'd255, 8'd255}},
        '{1'b1, REG_BRIGHTNESS, 16'd0,      10'd0,    1'b0, '{8'd0, 8'd0, 8'd0}},
        '{1'b0, REG_HUE_RATE,   16'd0,      10'd512,  1'b1, '{8'd0, 8'd0, 8'd0}},
        '{1'b1, REG_BRIGHTNESS, 16'd255,    10'd0,    1'b0, '{8'd0, 8'd0, 8'd0}},
        '{1'b1, REG_SATURATION, 16'd255,    10'd0,    1'b0, '{8'd0, 8'd0, 8'd0}},
        '{1'b1, REG_HUE_RATE,   16'd23039,  10'd0,    1'b0, '{8'd0, 8'd0, 8'd0}},
        '{1'b0, REG_HUE_RATE,   16'd0,      10'd171,  1'b0, '{8'd0, 8'd0, 8'd0}},
        '{1'b0, REG_HUE_RATE,   16'd0,      10'd171,  1'b0, '{8'd0, 8'd0, 8'd0}},
        '{1'b0, REG_HUE_RATE,   16'd0,      10'd171,  1'b0, '{8'd0, 8'd0, 8'd0}},
        '{1'b0, REG_HUE_RATE,   16'd0,      10'd171,  1'b0, '{8'd0, 8'd0, 8'd0}},
        '{1'b0, REG_HUE_RATE,   16'd0,      10'd171,  1'b0, '{8'd0, 8'd0, 8'd0}},
        '{1'b0, REG_HUE_RATE,   16'd0,      10'd171,  1'b0, '{8'd0, 8'd0, 8'd0}},
        '{1'b0, REG_HUE_RATE,   16'd0,      10'd1023, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{1'b1, REG_HUE_RATE,   16'hA601,   10'd0,    1'b0, '{8'd0, 8'd0, 8'd0}},
        '{1'b0, REG_HUE_RATE,   16'd0,      10'd1023, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{1'b0, REG_HUE_RATE,   16'd0,      10'd171,  1'b0, '{8'd0, 8'd0, 8'd0}},
        '{1'b1, REG_HUE_RATE,   16'h7FFF,   10'd0,    1'b0, '{8'd0, 8'd0, 8'd0}},
        '{1'b0, REG_HUE_RATE,   16'd0,      10'd1023, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{1'b1, REG_HUE_RATE,   16'h8000,   10'd0,    1'b0, '{8'd0, 8'd0, 8'd0}},
        '{1'b0, REG_HUE_RATE,   16'd0,      10'd1023, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{1'b1, REG_UNUSED,     16'hFFFF,   10'd0,    1'b0, '{8'd0, 8'd0, 8'd0}},
        '{1'b0, REG_HUE_RATE,   16'd0,      10'd300,  1'b0, '{8'd0, 8'd0, 8'd0}},
        '{1'b1, REG_SATURATION, 16'hFF80,   10'd0,    1'b0, '{8'd0, 8'd0, 8'd0}},
        '{1'b1, REG_BRIGHTNESS, 16'h00C8,   10'd0,    1'b0, '{8'd0, 8'd0, 8'd0}},
        '{1'b0, REG_HUE_RATE,   16'd0,      10'd1023, 1'b0, '{8'd0, 8'd0, 8'd0}}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [TIME_W-1:0]   i_elapsed_time;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [CHAN_W-1:0]   o_red;
    logic [CHAN_W-1:0]   o_green;
    logic [CHAN_W-1:0]   o_blue;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [IDX_W-1:0]    i_cfg_index;
    logic [RATE_W-1:0]   i_cfg_data;

    t_cfg              cfg_now;
    logic [PHASE_W-1:0] hue_now;
    t_rgb              rgb_due[$];
    t_rgb              rgb_head;

    int gap_pct;
    int stall_pct;
    int hold_ask;
    int hold_left;
    int quiet;
    int errors;
    int words_sent;
    int colors_seen;
    int reg_writes;

    hue_cycle_rgb_driver dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_elapsed_time (i_elapsed_time),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int unsigned fade_chan(input int unsigned v, input int unsigned s,
                                              input int unsigned x);
        return (v * (FRAC_SPAN - s * x)) / FRAC_SPAN;
    endfunction

    function automatic t_rgb advance_hue(input logic [TIME_W-1:0] dt);
        int          rate;
        int          prod;
        int          step;
        int          sum;
        int unsigned v;
        int unsigned s;
        int unsigned fr;
        int unsigned p;
        int unsigned q;
        int unsigned t;
        t_rgb        c;
        rate = $signed(cfg_now.hue_rate);
        prod = rate * int'(dt);
        step = (prod < 0) ? -((-prod) >>> TIME_W) : (prod >>> TIME_W);
        sum  = (int'(hue_now) + step) % HUE_TURN;
        if (sum < 0) begin
            sum += HUE_TURN;
        end
        hue_now = sum[PHASE_W-1:0];
        v = cfg_now.brightness;
        s = cfg_now.saturation;
        if (s == 0) begin
            c = '{v[7:0], v[7:0], v[7:0]};
        end else begin
            fr = hue_now % SECTOR_SPAN;
            p  = (v * (CHAN_FULL - s)) / CHAN_FULL;
            q  = fade_chan(v, s, fr);
            t  = fade_chan(v, s, SECTOR_SPAN - fr);
            case (SECT_W'(hue_now / SECTOR_SPAN))
                SECT_RED_YELLOW:   c = '{v[7:0], t[7:0], p[7:0]};
                SECT_YELLOW_GREEN: c = '{q[7:0], v[7:0], p[7:0]};
                SECT_GREEN_CYAN:   c = '{p[7:0], v[7:0], t[7:0]};
                SECT_CYAN_BLUE:    c = '{p[7:0], q[7:0], v[7:0]};
                SECT_BLUE_MAGENTA: c = '{t[7:0], p[7:0], v[7:0]};
                default:           c = '{v[7:0], p[7:0], q[7:0]};
            endcase
        end
        return c;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    task automatic send_tick(input logic [TIME_W-1:0] dt, input logic typed, input t_rgb want);
        t_rgb c;
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            i_elapsed_time <= TIME_W'($urandom);
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_elapsed_time <= dt;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        c = advance_hue(dt);
        rgb_due.push_back(typed ? want : c);
        words_sent++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (rgb_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [RATE_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_HUE_RATE:   cfg_now.hue_rate   = data;
            REG_SATURATION: cfg_now.saturation = data[CHAN_W-1:0];
            REG_BRIGHTNESS: cfg_now.brightness = data[CHAN_W-1:0];
            default: ;
        endcase
        reg_writes++;
        @(posedge i_clk);
    endtask

    function automatic logic [RATE_W-1:0] pick_rate();
        case ($urandom_range(9))
            0:       return 16'd23039;
            1:       return -16'sd23039;
            2:       return 16'd0;
            3:       return RATE_W'($urandom);
            default: return RATE_W'(int'($urandom_range(46078)) - 23039);
        endcase
    endfunction

    function automatic logic [RATE_W-1:0] pick_level();
        logic [RATE_W-1:0] d;
        d = RATE_W'($urandom);
        case ($urandom_range(5))
            0:       d[CHAN_W-1:0] = 8'd0;
            1:       d[CHAN_W-1:0] = 8'd255;
            default: ;
        endcase
        return d;
    endfunction

    function automatic logic [TIME_W-1:0] pick_time();
        case ($urandom_range(7))
            0:       return 10'd0;
            1:       return 10'd1023;
            default: return TIME_W'($urandom_range(1023));
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (hold_ask != 0) begin
            hold_left = hold_ask;
            hold_ask  = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            colors_seen++;
            if (rgb_due.size() == 0) begin
                report_mismatch("unexpected word, red", o_red, 0);
            end else begin
                rgb_head = rgb_due.pop_front();
                if (o_red !== rgb_head.red) begin
                    report_mismatch("red", o_red, rgb_head.red);
                end
                if (o_green !== rgb_head.green) begin
                    report_mismatch("green", o_green, rgb_head.green);
                end
                if (o_blue !== rgb_head.blue) begin
                    report_mismatch("blue", o_blue, rgb_head.blue);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        hold_ask    = 0;
        hold_left   = 0;
        quiet       = 0;
        errors      = 0;
        words_sent  = 0;
        colors_seen = 0;
        reg_writes  = 0;
        gap_pct     = 31;
        stall_pct   = 61;
        hue_now     = '0;
        cfg_now     = '{RATE_RESET, CHAN_FULL, CHAN_FULL};
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_elapsed_time <= '0;
        i_out_stall    <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= REG_HUE_RATE;
        i_cfg_data     <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < PLAN_LEN; i++) begin
            if (PLAN[i].is_cfg) begin
                settle();
                write_reg(PLAN[i].idx, PLAN[i].data);
            end else begin
                send_tick(PLAN[i].dt, PLAN[i].typed, PLAN[i].rgb);
            end
        end

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 9) begin
                gap_pct   = 61;
                stall_pct = 31;
            end else if (seg == 18) begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            settle();
            if ($urandom_range(1)) write_reg(REG_HUE_RATE, pick_rate());
            if ($urandom_range(1)) write_reg(REG_SATURATION, pick_level());
            if ($urandom_range(1)) write_reg(REG_BRIGHTNESS, pick_level());
            if ($urandom_range(7) == 0) write_reg(REG_UNUSED, RATE_W'($urandom));
            if (seg == 6 || seg == 22) begin
                hold_ask = HOLD_CYCLES;
            end
            for (int n = 0; n < SEG_WORDS; n++) begin
                if (seg == 14 && n == SEG_WORDS / 2) begin
                    settle();
                end
                send_tick(pick_time(), 1'b0, '0);
            end
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (rgb_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2 * LATENCY) @(posedge i_clk);

        $display("Sent %0d time words and checked %0d colors across %0d register writes,",
                 words_sent, colors_seen, reg_writes);
        $display("with sender gaps, receiver stalls and long output hold-offs; %0d mismatches.",
                 errors);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
